>>> sv/tensor_coherence_pixel_assert.svh
// assertion macros for the coherence pipeline
`ifndef TENSOR_COHERENCE_PIXEL_ASSERT_SVH
`define TENSOR_COHERENCE_PIXEL_ASSERT_SVH

// implication checked on every clock edge outside reset
`define TCP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tcp check failed");

// implication whose consequent is checked in the cycle after the antecedent
`define TCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tcp check failed");

`endif

>>> sv/tcp_pkg.sv
`timescale 1ns / 1ps
package tcp_pkg;

  localparam int unsigned RootW  = 33;
  localparam int unsigned QuotW  = 17;
  localparam logic [QuotW-1:0] OneQ16 = 17'd65536;

  // register byte addresses
  localparam logic [2:0] AddrFloor = 3'd0;

  typedef struct packed {
    logic [31:0] tensor_xx;
    logic [31:0] tensor_yy;
    logic signed [31:0] tensor_xy;
  } in_item_t;

  typedef struct packed {
    logic [16:0] coherence;
    logic        flat_pixel;
  } out_item_t;

  // side info carried with each pixel
  typedef struct packed {
    logic        flat;
    logic        zero_trace;
    logic [32:0] trace;
  } side_t;

endpackage

>>> sv/tcp_front.sv
`timescale 1ns / 1ps
// trace, differences and squares, spread sum
module tcp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  tcp_pkg::in_item_t item_i,
  input  logic [32:0]       floor_i,
  output logic              valid_o,
  output logic [65:0]       spread_o,
  output tcp_pkg::side_t    side_o
);

  logic        v1_q, v2_q;
  logic [31:0] diff_q, xyabs_q;
  tcp_pkg::side_t side1_q, side2_q;
  logic [63:0] dsq_q, csq_q;
  logic [32:0] trace_d;
  logic [31:0] xyabs_d;

  assign trace_d = {1'b0, item_i.tensor_xx} + {1'b0, item_i.tensor_yy};
  assign xyabs_d = item_i.tensor_xy[31] ? (~item_i.tensor_xy + 32'd1) : item_i.tensor_xy;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // stage one: magnitudes and trace
  always_ff @(posedge clk_i) begin
    diff_q  <= (item_i.tensor_xx >= item_i.tensor_yy) ? item_i.tensor_xx - item_i.tensor_yy
                                                      : item_i.tensor_yy - item_i.tensor_xx;
    xyabs_q <= xyabs_d;
    side1_q.trace      <= trace_d;
    side1_q.flat       <= trace_d < floor_i;
    side1_q.zero_trace <= trace_d == 33'd0;
  end

  // stage two: squares (2xy squared is 4 * |xy| squared)
  always_ff @(posedge clk_i) begin
    dsq_q   <= diff_q * diff_q;
    csq_q   <= xyabs_q * xyabs_q;
    side2_q <= side1_q;
  end

  assign valid_o  = v2_q;
  assign spread_o = {2'b00, dsq_q} + {csq_q, 2'b00};
  assign side_o   = side2_q;

endmodule

>>> sv/tcp_sqrt.sv
`timescale 1ns / 1ps
// pipelined restoring square root, one root bit per stage
module tcp_sqrt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [65:0]    rad_i,
  input  tcp_pkg::side_t side_i,
  output logic           valid_o,
  output logic [32:0]    root_o,
  output tcp_pkg::side_t side_o
);

  localparam int unsigned N = tcp_pkg::RootW;

  logic [N-1:0]   v_q;
  logic [65:0]    rem_q  [N];
  logic [32:0]    root_q [N];
  tcp_pkg::side_t side_q [N];

  // valid bits travel with the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[N-2:0], valid_i};
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam int unsigned B = N - 1 - s;
    logic [65:0]    rem_in;
    logic [32:0]    root_in;
    tcp_pkg::side_t side_in;
    logic [67:0]    trial;
    logic [67:0]    remx;
    if (s == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign side_in = side_q[s-1];
    end
    // trial subtract of (2*root*2^b + 2^2b)
    assign trial = ({35'd0, root_in} << (B + 1)) + (68'd1 << (2 * B));
    assign remx  = {2'b00, rem_in};
    always_ff @(posedge clk_i) begin
      side_q[s] <= side_in;
      if (remx >= trial) begin
        rem_q[s]  <= 66'(remx - trial);
        root_q[s] <= root_in | (33'd1 << B);
      end else begin
        rem_q[s]  <= rem_in;
        root_q[s] <= root_in;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign root_o  = root_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

>>> sv/tcp_div.sv
`timescale 1ns / 1ps
// pipelined restoring divider for root*2^16 / trace, one quotient bit per stage
module tcp_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [32:0]          root_i,
  input  tcp_pkg::side_t       side_i,
  output logic                 valid_o,
  output tcp_pkg::out_item_t   item_o
);

  // sixteen quotient bits: root < trace keeps the quotient below 2^16
  localparam int unsigned N = tcp_pkg::QuotW - 1;

  logic [N-1:0]   v_q;
  logic [32:0]    rem_q  [N];
  logic [N-1:0]   quo_q  [N];
  logic           big_q  [N];
  logic           any_q  [N];
  tcp_pkg::side_t side_q [N];

  // valid bits travel with the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[N-2:0], valid_i};
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [32:0]    rem_in;
    logic [N-1:0]   quo_in;
    logic           big_in;
    logic           any_in;
    tcp_pkg::side_t side_in;
    logic [33:0]    shl;
    if (s == 0) begin : g_first
      // remainder starts as the root; a root at or above the trace saturates
      assign rem_in  = root_i;
      assign quo_in  = '0;
      assign big_in  = root_i >= side_i.trace;
      assign any_in  = root_i != 33'd0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign big_in  = big_q[s-1];
      assign any_in  = any_q[s-1];
      assign side_in = side_q[s-1];
    end
    // low bits of root*2^16 are all zero
    assign shl = {rem_in, 1'b0};
    always_ff @(posedge clk_i) begin
      side_q[s] <= side_in;
      big_q[s]  <= big_in;
      any_q[s]  <= any_in;
      if (shl >= {1'b0, side_in.trace}) begin
        rem_q[s] <= 33'(shl - {1'b0, side_in.trace});
        quo_q[s] <= {quo_in[N-2:0], 1'b1};
      end else begin
        rem_q[s] <= shl[32:0];
        quo_q[s] <= {quo_in[N-2:0], 1'b0};
      end
    end
  end

  // final select: flat, zero trace, saturation, else the quotient
  always_comb begin
    item_o.flat_pixel = side_q[N-1].flat;
    if (side_q[N-1].flat) begin
      item_o.coherence = '0;
    end else if (side_q[N-1].zero_trace) begin
      item_o.coherence = any_q[N-1] ? tcp_pkg::OneQ16 : '0;
    end else if (big_q[N-1]) begin
      item_o.coherence = tcp_pkg::OneQ16;
    end else begin
      item_o.coherence = {1'b0, quo_q[N-1]};
    end
  end

  assign valid_o = v_q[N-1];

endmodule

>>> sv/tensor_coherence_pixel.sv
`timescale 1ns / 1ps
// Structure tensor coherence, one pixel per clock.
// Input: drive tensor_xx/yy/xy on item_i and raise start; busy is always low
// so a pixel is taken on every cycle start is high.
// Output: result_o holds coherence (Q1.16, 65536 = 1.0) and flat_pixel for the one
// cycle that done_o is high; results leave in input order.
// Pipeline: done_o rises once the pixel has passed through 2 front
// stages, 33 root stages and 16 divide stages; throughput one pixel per cycle,
// set by the fully pipelined root and divider, one bit per stage.
// Configuration: APB register 0 at address 0, denominator_floor (33 bits),
// reset value 1; write only while no pixels are in flight.
// Reset clears all valid bits; pixels in flight are dropped.
// The receiver cannot stall: every result is presented exactly once.
module tensor_coherence_pixel (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  tcp_pkg::in_item_t          item_i,
  output logic                       done_o,
  output tcp_pkg::out_item_t         result_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);

  logic [32:0]    floor_q;
  logic           fv, sv_v;
  logic [65:0]    spread;
  logic [32:0]    root;
  tcp_pkg::side_t fs, ss;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // floor register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= 33'd1;
    end else if (psel && penable && pwrite && paddr == tcp_pkg::AddrFloor) begin
      floor_q <= pwdata[32:0];
    end
  end

  assign prdata = (paddr == tcp_pkg::AddrFloor) ? {31'd0, floor_q} : 64'd0;

  tcp_front u_front (
    .clk_i, .rst_ni, .valid_i(start), .item_i, .floor_i(floor_q),
    .valid_o(fv), .spread_o(spread), .side_o(fs)
  );

  tcp_sqrt u_sqrt (
    .clk_i, .rst_ni, .valid_i(fv), .rad_i(spread), .side_i(fs),
    .valid_o(sv_v), .root_o(root), .side_o(ss)
  );

  tcp_div u_div (
    .clk_i, .rst_ni, .valid_i(sv_v), .root_i(root), .side_i(ss),
    .valid_o(done_o), .item_o(result_o)
  );

  `include "tensor_coherence_pixel_assert.svh"

  `TCP_ASSERT_IMP(a_flat_zero, done_o && result_o.flat_pixel, result_o.coherence == 17'd0)
  `TCP_ASSERT_IMP(a_sat, done_o, result_o.coherence <= tcp_pkg::OneQ16)
  `TCP_ASSERT_IMP(a_never_busy, 1'b1, !busy)

endmodule
